// ===== hdl/afr_pkg.sv =====
package afr_pkg;

  // Register map, byte address = 4 * index
  localparam int unsigned RegStartByte  = 0;
  localparam int unsigned RegAckCommand = 1;
  localparam int unsigned AddrW         = 3;

  localparam logic [7:0] StartByteRst  = 8'hAA;
  localparam logic [7:0] AckCommandRst = 8'h81;

  // Width of the packed result word on the master side
  localparam int unsigned ResDataW = 96;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] ack_command;
  } cfg_t;

  typedef struct packed {
    logic [31:0] bad_ack_count;
    logic [31:0] good_ack_count;
    logic [7:0]  ack_status;
    logic [7:0]  ack_for_cmd;
    logic        ack_seen;
    logic        length_error;
    logic [4:0]  pay_len;
    logic [7:0]  frame_cmd;
    logic        checksum_ok;
    logic        frame_done;
  } res_t;

endpackage

// ===== hdl/ack_frame_receiver.sv =====
// Byte-stream frame receiver. Each byte taken on the slave stream yields exactly one
// result on the master stream, in order. Frames are start byte, command, length,
// payload, then a checksum equal to the 8-bit sum of command, length and payload.
// A length above PAYLOAD_MAX aborts the frame (length_error); a byte that ends or
// aborts a frame opens a new one at once if it equals the start byte. A good
// acknowledge frame (command = ack_command, length two) reports the acknowledged
// command and status and bumps the good or bad counter. Throughput is one byte per
// clock: the byte is held in an input register, parsed by one level of logic and
// the result lands in an output register, so a stall on the master side only
// holds the slave side once both registers are full. start_byte (0x0) and
// ack_command (0x4) are to be written over the APB port only while the stream is
// idle; the user is bound to this, the block itself does not enforce it.
module ack_frame_receiver #(
  parameter int unsigned PAYLOAD_MAX = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // slave stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // [7:0] rx_byte
  // master stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // [0] checksum_ok, [8:1] frame_cmd, [13:9] pay_len, [14] length_error,
  // [15] ack_seen, [23:16] ack_for_cmd, [31:24] ack_status,
  // [63:32] good_ack_count, [95:64] bad_ack_count
  output logic [afr_pkg::ResDataW-1:0] m_axis_tdata,
  output logic                      m_axis_tlast,   // frame_done
  // APB configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [afr_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import afr_pkg::*;

  cfg_t       cfg;
  res_t       res;
  res_t       out_q;
  logic       out_valid_q;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       advance;
  logic       in_take;

  afr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // request moves from input register to output register when the latter is free
  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;
  assign in_take       = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  afr_parser #(
    .PayloadMax (PAYLOAD_MAX)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (advance),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_q.frame_done;
  assign m_axis_tdata  = {out_q.bad_ack_count, out_q.good_ack_count, out_q.ack_status,
                          out_q.ack_for_cmd, out_q.ack_seen, out_q.length_error,
                          out_q.pay_len, out_q.frame_cmd, out_q.checksum_ok};

endmodule

// ===== hdl/afr_cfg_regs.sv =====
module afr_cfg_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [afr_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output afr_pkg::cfg_t             cfg_o
);
  import afr_pkg::*;

  cfg_t cfg_q;
  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte  <= StartByteRst;
      cfg_q.ack_command <= AckCommandRst;
    end else if (wr_en) begin
      if (reg_sel == 1'(RegAckCommand)) begin
        cfg_q.ack_command <= pwdata[7:0];
      end else begin
        cfg_q.start_byte <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    if (reg_sel == 1'(RegAckCommand)) begin
      prdata = {24'd0, cfg_q.ack_command};
    end else begin
      prdata = {24'd0, cfg_q.start_byte};
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/afr_parser.sv =====
module afr_parser #(
  parameter int unsigned PayloadMax = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  afr_pkg::cfg_t cfg_i,
  input  logic          step_i,
  input  logic [7:0]    byte_i,
  output afr_pkg::res_t res_o
);
  import afr_pkg::*;

  localparam int unsigned LenW = $clog2(PayloadMax + 1);

  typedef enum logic [2:0] {
    PhWait    = 3'd0,
    PhCmd     = 3'd1,
    PhLen     = 3'd2,
    PhPayload = 3'd3,
    PhCheck   = 3'd4
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [7:0]      cmd_q, cmd_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] idx_q, idx_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      pay0_q, pay1_q;
  logic [31:0]     good_q, good_d;
  logic [31:0]     bad_q, bad_d;
  logic            pay0_we, pay1_we;
  logic            is_start;
  logic [7:0]      sum_add;
  logic [LenW:0]   idx_inc;
  res_t            res;

  assign is_start = (byte_i == cfg_i.start_byte);
  assign sum_add  = sum_q + byte_i;
  assign idx_inc  = {1'b0, idx_q} + 1'b1;

  always_comb begin
    phase_d = phase_q;
    cmd_d   = cmd_q;
    len_d   = len_q;
    idx_d   = idx_q;
    sum_d   = sum_q;
    good_d  = good_q;
    bad_d   = bad_q;
    pay0_we = 1'b0;
    pay1_we = 1'b0;
    res     = '0;

    unique case (phase_q)
      PhWait: begin
        if (is_start) begin
          phase_d = PhCmd;
          len_d   = '0;
          idx_d   = '0;
          sum_d   = '0;
        end
      end
      PhCmd: begin
        cmd_d   = byte_i;
        sum_d   = byte_i;
        phase_d = PhLen;
      end
      PhLen: begin
        if ({1'b0, byte_i} > 9'(PayloadMax)) begin
          // bad length aborts; the same byte may open the next frame
          res.length_error = 1'b1;
          phase_d = is_start ? PhCmd : PhWait;
          cmd_d   = '0;
          len_d   = '0;
          idx_d   = '0;
          sum_d   = '0;
        end else begin
          len_d   = LenW'(byte_i);
          sum_d   = sum_add;
          idx_d   = '0;
          phase_d = (byte_i == 8'd0) ? PhCheck : PhPayload;
        end
      end
      PhPayload: begin
        pay0_we = (idx_q == '0);
        pay1_we = (idx_q == LenW'(1));
        idx_d   = idx_inc[LenW-1:0];
        sum_d   = sum_add;
        if (idx_inc >= {1'b0, len_q}) begin
          phase_d = PhCheck;
        end
      end
      PhCheck: begin
        res.frame_done = 1'b1;
        res.frame_cmd  = cmd_q;
        res.pay_len    = 5'(len_q);
        if (byte_i == sum_q) begin
          res.checksum_ok = 1'b1;
          if (cmd_q == cfg_i.ack_command && len_q == LenW'(2)) begin
            res.ack_seen    = 1'b1;
            res.ack_for_cmd = pay0_q;
            res.ack_status  = pay1_q;
            if (pay1_q != 8'd0) begin
              bad_d = bad_q + 32'd1;
            end else begin
              good_d = good_q + 32'd1;
            end
          end
        end
        phase_d = is_start ? PhCmd : PhWait;
        cmd_d   = '0;
        len_d   = '0;
        idx_d   = '0;
        sum_d   = '0;
      end
      default: begin
        phase_d = PhWait;
        cmd_d   = '0;
        len_d   = '0;
        idx_d   = '0;
        sum_d   = '0;
      end
    endcase

    res.good_ack_count = good_d;
    res.bad_ack_count  = bad_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhWait;
      cmd_q   <= '0;
      len_q   <= '0;
      idx_q   <= '0;
      sum_q   <= '0;
      good_q  <= '0;
      bad_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      sum_q   <= sum_d;
      good_q  <= good_d;
      bad_q   <= bad_d;
    end
  end

  // first two payload bytes, no reset
  always_ff @(posedge clk_i) begin
    if (step_i && pay0_we) begin
      pay0_q <= byte_i;
    end
    if (step_i && pay1_we) begin
      pay1_q <= byte_i;
    end
  end

  assign res_o = res;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import afr_pkg::*;

  localparam int unsigned PAYLOAD_MAX    = 16;
  localparam int unsigned CLK_HALF       = 4;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned BYTES_PER_SET  = 225;
  localparam int unsigned N_SETTINGS     = 6;

  // parser phases of the local frame predictor
  typedef enum logic [2:0] {
    PhWait, PhCmd, PhLen, PhPayload, PhCheck
  } parse_phase_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [ResDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  ack_frame_receiver #(
    .PAYLOAD_MAX(PAYLOAD_MAX)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Frame predictor: own copy of the registers and parser state. One report is
  // predicted per received byte, in order of acceptance.
  // ---------------------------------------------------------------------------
  cfg_t         frame_cfg;
  parse_phase_e parse_phase;
  logic [7:0]   frame_cmd_q;
  logic [4:0]   pay_len_q;
  logic [4:0]   payload_idx;
  logic [7:0]   frame_sum;
  logic [7:0]   payload_head [2];
  logic [31:0]  good_acks;
  logic [31:0]  bad_acks;

  res_t expected_reports [$];

  int unsigned err_cnt       = 0;
  int unsigned bytes_sent    = 0;
  int unsigned frames_closed = 0;
  int unsigned len_aborts    = 0;
  int unsigned src_idle_pct  = 25;
  int unsigned sink_idle_pct = 25;
  int unsigned quiet_cycles  = 0;

  function automatic void parser_idle();
    parse_phase = PhWait;
    frame_cmd_q = '0;
    pay_len_q   = '0;
    payload_idx = '0;
    frame_sum   = '0;
  endfunction

  function automatic void open_frame();
    parse_phase = PhCmd;
    pay_len_q   = '0;
    payload_idx = '0;
    frame_sum   = '0;
  endfunction

  // a byte that ends or aborts a frame may itself open the next one
  function automatic void close_frame(input logic [7:0] b);
    parser_idle();
    if (b == frame_cfg.start_byte) open_frame();
  endfunction

  function automatic res_t predict_frame_byte(input logic [7:0] b);
    res_t r;
    r = '0;
    case (parse_phase)
      PhWait: begin
        if (b == frame_cfg.start_byte) open_frame();
      end
      PhCmd: begin
        // any byte here is the command, start byte included
        frame_cmd_q = b;
        frame_sum   = b;
        parse_phase = PhLen;
      end
      PhLen: begin
        frame_sum = frame_sum + b;
        if (b > PAYLOAD_MAX) begin
          r.length_error = 1'b1;
          close_frame(b);
        end else begin
          pay_len_q   = b[4:0];
          payload_idx = '0;
          parse_phase = (b == 8'd0) ? PhCheck : PhPayload;
        end
      end
      PhPayload: begin
        if (payload_idx < 2) payload_head[payload_idx[0]] = b;
        payload_idx = payload_idx + 1'b1;
        frame_sum   = frame_sum + b;
        if (payload_idx >= pay_len_q) parse_phase = PhCheck;
      end
      PhCheck: begin
        r.frame_done = 1'b1;
        r.frame_cmd  = frame_cmd_q;
        r.pay_len    = pay_len_q;
        if (b == frame_sum) begin
          r.checksum_ok = 1'b1;
          if (frame_cmd_q == frame_cfg.ack_command && pay_len_q == 5'd2) begin
            r.ack_seen    = 1'b1;
            r.ack_for_cmd = payload_head[0];
            r.ack_status  = payload_head[1];
            if (payload_head[1] != 8'd0) bad_acks = bad_acks + 1;
            else good_acks = good_acks + 1;
          end
        end
        close_frame(b);
      end
      default: parser_idle();
    endcase
    r.good_ack_count = good_acks;
    r.bad_ack_count  = bad_acks;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Report checker: every accepted master-side request is matched against the
  // oldest prediction. tdata carries everything but frame_done, which is tlast.
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  task automatic check_report();
    res_t e;
    if (expected_reports.size() == 0) begin
      $error("report with nothing expected: tdata %0h tlast %0b", m_axis_tdata, m_axis_tlast);
      err_cnt++;
    end else begin
      e = expected_reports.pop_front();
      compare_field("frame_done",     32'(e.frame_done),   32'(m_axis_tlast));
      compare_field("checksum_ok",    32'(e.checksum_ok),  32'(m_axis_tdata[0]));
      compare_field("frame_cmd",      32'(e.frame_cmd),    32'(m_axis_tdata[8:1]));
      compare_field("pay_len",        32'(e.pay_len),      32'(m_axis_tdata[13:9]));
      compare_field("length_error",   32'(e.length_error), 32'(m_axis_tdata[14]));
      compare_field("ack_seen",       32'(e.ack_seen),     32'(m_axis_tdata[15]));
      compare_field("ack_for_cmd",    32'(e.ack_for_cmd),  32'(m_axis_tdata[23:16]));
      compare_field("ack_status",     32'(e.ack_status),   32'(m_axis_tdata[31:24]));
      compare_field("good_ack_count", e.good_ack_count,    m_axis_tdata[63:32]);
      compare_field("bad_ack_count",  e.bad_ack_count,     m_axis_tdata[95:64]);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_report();
  end

  // random back-pressure on the report side
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // watchdog: cycles without any accepted request on either stream
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[ack_frame_receiver] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // send one received byte; random gaps before it, prediction on acceptance
  task automatic push_byte(input logic [7:0] b);
    res_t r;
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = predict_frame_byte(b);
    expected_reports.push_back(r);
    bytes_sent++;
    if (r.frame_done) frames_closed++;
    if (r.length_error) len_aborts++;
  endtask

  // stop sending and wait until every predicted report has been seen
  task automatic drain_reports();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [AddrW-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic read_back(input string name, input logic [AddrW-1:0] addr,
                           input logic [7:0] exp_v);
    logic [31:0] rd;
    apb_access(1'b0, addr, '0, rd);
    compare_field(name, {24'd0, exp_v}, rd);
  endtask

  // write both registers (upper write bits random, they must be dropped)
  task automatic apply_setting(input logic [7:0] sb, input logic [7:0] ac);
    logic [31:0] rd;
    drain_reports();
    apb_access(1'b1, AddrW'(RegStartByte * 4), {24'($urandom() >> 8), sb}, rd);
    frame_cfg.start_byte = sb;
    apb_access(1'b1, AddrW'(RegAckCommand * 4), {24'($urandom() >> 8), ac}, rd);
    frame_cfg.ack_command = ac;
    read_back("start_byte", AddrW'(RegStartByte * 4), frame_cfg.start_byte);
    read_back("ack_command", AddrW'(RegAckCommand * 4), frame_cfg.ack_command);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_register_reset();
    read_back("start_byte", AddrW'(RegStartByte * 4), StartByteRst);
    read_back("ack_command", AddrW'(RegAckCommand * 4), AckCommandRst);
  endtask

  // hand-built sequence under the reset register values
  task automatic test_directed_frames();
    logic [7:0] seq [$];
    seq = '{
      // good acknowledge for command 05
      8'hAA, 8'h81, 8'h02, 8'h05, 8'h00, 8'h88,
      // acknowledge with status FF, payload at its top value
      8'hAA, 8'h81, 8'h02, 8'hFF, 8'hFF, 8'h81,
      // start byte as command, zero length, checksum equal to the start byte
      // so the parser reopens straight away
      8'hAA, 8'hAA, 8'h00, 8'hAA,
      // length byte equal to the start byte: abort and reopen
      8'h81, 8'hAA,
      // length 255: abort, back to waiting
      8'h00, 8'hFF,
      // stray byte while waiting, then an acknowledge with a bad checksum
      8'h00, 8'hAA, 8'h81, 8'h02, 8'h00, 8'h00, 8'h00
    };
    foreach (seq[i]) push_byte(seq[i]);
  endtask

  // mostly well-formed frames with random content, some noise, broken
  // checksums and over-long lengths; pauses once until all reports are in
  task automatic test_random_frames(input int unsigned n_bytes);
    int unsigned first;
    int unsigned pause_at;
    int unsigned r;
    logic        paused;
    logic [7:0]  cmd;
    logic [7:0]  len;
    logic [7:0]  pb;
    logic [7:0]  sum;
    first    = bytes_sent;
    pause_at = $urandom_range(n_bytes - 1);
    paused   = 1'b0;
    while (bytes_sent - first < n_bytes) begin
      if (!paused && bytes_sent - first >= pause_at) begin
        drain_reports();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(4, 1)) push_byte(8'($urandom_range(255)));
      end
      r = $urandom_range(99);
      if (r < 50) cmd = frame_cfg.ack_command;
      else if (r < 58) cmd = frame_cfg.start_byte;
      else cmd = 8'($urandom_range(255));
      r = $urandom_range(99);
      if (r < 45) len = 8'd2;
      else if (r < 55) len = 8'd0;
      else if (r < 65) len = 8'(PAYLOAD_MAX);
      else if (r < 75) len = 8'($urandom_range(255, PAYLOAD_MAX + 1));
      else len = 8'($urandom_range(PAYLOAD_MAX, 1));
      push_byte(frame_cfg.start_byte);
      push_byte(cmd);
      push_byte(len);
      sum = cmd + len;
      if (len <= PAYLOAD_MAX) begin
        for (int unsigned i = 0; i < len; i++) begin
          // status byte of a would-be acknowledge is OK half the time
          pb = (len == 8'd2 && i == 1 && $urandom_range(1)) ? 8'd0 : 8'($urandom_range(255));
          push_byte(pb);
          sum = sum + pb;
        end
        push_byte(($urandom_range(99) < 85) ? sum : 8'($urandom_range(255)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] set_start [N_SETTINGS];
    logic [7:0] set_ack   [N_SETTINGS];

    // register settings: extremes, the start byte at and just above the
    // payload bound, the reset start byte, and one random pair
    set_start = '{8'h00, 8'hFF, 8'h10, 8'h11, 8'hAA, 8'h00};
    set_ack   = '{8'hFF, 8'h00, 8'h81, 8'h00, 8'hFF, 8'h00};
    set_start[N_SETTINGS-1] = 8'($urandom_range(255));
    set_ack[N_SETTINGS-1]   = 8'($urandom_range(255));

    frame_cfg.start_byte  = StartByteRst;
    frame_cfg.ack_command = AckCommandRst;
    parser_idle();
    payload_head[0] = '0;
    payload_head[1] = '0;
    good_acks = '0;
    bad_acks  = '0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_register_reset();
    test_directed_frames();
    test_random_frames(BYTES_PER_SET);
    for (int unsigned k = 0; k < N_SETTINGS; k++) begin
      apply_setting(set_start[k], set_ack[k]);
      // one whole setting without any gaps on either side
      src_idle_pct  = (k == 2) ? 0 : 25;
      sink_idle_pct = (k == 2) ? 0 : 25;
      test_random_frames(BYTES_PER_SET);
    end

    drain_reports();
    repeat (10) @(posedge clk_i);

    $display("[tb] %0d bytes parsed, %0d frames closed, %0d length aborts",
             bytes_sent, frames_closed, len_aborts);
    $display("[tb] acknowledges %0d good / %0d bad over %0d register settings",
             good_acks, bad_acks, N_SETTINGS + 1);
    if (err_cnt == 0) begin
      $display("[ack_frame_receiver] OK");
    end else begin
      $display("[ack_frame_receiver] ERROR");
    end
    $finish;
  end

endmodule

// ===== ack_frame_receiver.f =====
hdl/afr_pkg.sv
hdl/afr_cfg_regs.sv
hdl/afr_parser.sv
hdl/ack_frame_receiver.sv
tb/tb_top.sv
